@@ rtl/frs_pkg.sv @@
package frs_pkg;

    // Input item: message (mode 0) or dump request (mode 1)
    typedef struct packed {
        logic        mode;
        logic [31:0] ident;
    } t_frs_in;

    // Result item: one held identifier of a dump
    typedef struct packed {
        logic [31:0] entry;
        logic        entry_valid;
        logic [5:0]  held_count;
        logic        last;
    } t_frs_out;

    // Per-cycle operation broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // shift toward the old end, new identifier enters cell 0
        logic rotate;   // shift toward the head, head wraps to the last held cell
    } t_frs_ctl;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DUMP
    } t_frs_state;

    localparam logic       MODE_MSG     = 1'b0;
    localparam logic [5:0] CAP_RESET    = 6'd32;

endpackage

@@ rtl/frs_cell.sv @@
module frs_cell #(
    parameter int IDW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frs_pkg::t_frs_ctl  i_ctl,
    input  logic               i_allow,
    input  logic               i_wrap,
    input  logic [IDW-1:0]     i_prev_ident,
    input  logic               i_prev_valid,
    input  logic [IDW-1:0]     i_next_ident,
    input  logic [IDW-1:0]     i_head_ident,
    input  logic [IDW-1:0]     i_cmp_ident,
    output logic [IDW-1:0]     o_ident,
    output logic               o_valid,
    output logic               o_hit
);
    import frs_pkg::*;

    logic [IDW-1:0] r_ident;
    logic           r_valid;

    // Take the newer neighbor's slot on insert, the older one's on rotate
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_ident <= i_prev_ident;
        end else if (i_ctl.rotate) begin
            r_ident <= i_wrap ? i_head_ident : i_next_ident;
        end
    end

    // Drop the slot on insert when it falls beyond the capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert) begin
            r_valid <= i_prev_valid & i_allow;
        end
    end

    assign o_ident = r_ident;
    assign o_valid = r_valid;
    assign o_hit   = r_valid && (r_ident == i_cmp_ident);

endmodule

@@ rtl/fifo_recent_id_set.sv @@
// Messages: accepted one per cycle outside a dump, no result; a new identifier is held
// the next cycle. Dump: stalls the input until its last result, one result per cycle
// from the head cell while the output is not stalled, as the chain rotates back to its
// original order. Synchronous active-low reset clears all valid marks, the fill count
// and the output valid flag; capacity returns to 32. Identifier slots are not cleared.
module fifo_recent_id_set #(
    parameter int MAX_ENTRIES = 32,
    parameter int IDENT_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  frs_pkg::t_frs_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output frs_pkg::t_frs_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [5:0]        i_cfg_data
);
    import frs_pkg::*;

    localparam int IDW   = (IDENT_BITS < 32) ? IDENT_BITS : 32;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [5:0]       r_cap;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    t_frs_state       r_state;
    t_frs_state       n_state;
    logic             r_out_valid;
    t_frs_out         r_out;
    t_frs_out         n_out;

    logic [CNT_W-1:0] w_cap_eff;
    logic [CNT_W-1:0] w_keep;
    logic [IDW-1:0]   w_cmp;
    logic             w_accept;
    logic             w_hit;
    logic             w_emit;
    logic             w_slot_free;
    t_frs_ctl         w_ctl;

    logic [IDW-1:0]   w_ident [MAX_ENTRIES];
    logic             w_valid [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_hits;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state == ST_DUMP);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_cmp       = i_in_data.ident[IDW-1:0];
    assign w_hit       = |w_hits;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Clamp capacity into 1..MAX_ENTRIES
    always_comb begin
        if (r_cap == 6'd0) begin
            w_cap_eff = CNT_W'(1);
        end else if ({1'b0, r_cap} > 7'(MAX_ENTRIES)) begin
            w_cap_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            w_cap_eff = CNT_W'(r_cap);
        end
    end

    // Survivors of an insert, then the new fill
    assign w_keep = (r_fill >= w_cap_eff) ? (w_cap_eff - CNT_W'(1)) : r_fill;
    assign n_fill = w_keep + CNT_W'(1);

    // Chain of cells, cell 0 is the newest
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [IDW-1:0] w_prev_ident;
        logic           w_prev_valid;
        logic [IDW-1:0] w_next_ident;

        if (i == 0) begin : g_head
            assign w_prev_ident = w_cmp;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_ident = w_ident[i-1];
            assign w_prev_valid = w_valid[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_tail
            assign w_next_ident = w_ident[0];
        end else begin : g_mid
            assign w_next_ident = w_ident[i+1];
        end

        frs_cell #(
            .IDW (IDW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_allow      (CNT_W'(i) < w_cap_eff),
            .i_wrap       (CNT_W'(i) == (r_fill - CNT_W'(1))),
            .i_prev_ident (w_prev_ident),
            .i_prev_valid (w_prev_valid),
            .i_next_ident (w_next_ident),
            .i_head_ident (w_ident[0]),
            .i_cmp_ident  (w_cmp),
            .o_ident      (w_ident[i]),
            .o_valid      (w_valid[i]),
            .o_hit        (w_hits[i])
        );
    end

    // State register and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_fill  <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_ctl.insert) begin
                r_fill <= n_fill;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Next state, chain operation and result
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        w_ctl.insert = 1'b0;
        w_ctl.rotate = 1'b0;
        w_emit       = 1'b0;
        n_out.entry       = 32'(w_ident[0]);
        n_out.entry_valid = (r_fill != '0);
        n_out.held_count  = 6'(r_fill);
        n_out.last        = (r_fill == '0) || (r_idx == (r_fill - CNT_W'(1)));
        if (r_fill == '0) begin
            n_out.entry = '0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.mode == MODE_MSG) begin
                        w_ctl.insert = !w_hit;
                    end else begin
                        n_state = ST_DUMP;
                        n_idx   = '0;
                    end
                end
            end
            ST_DUMP: begin
                if (w_slot_free) begin
                    w_emit       = 1'b1;
                    w_ctl.rotate = (r_fill != '0);
                    if (n_out.last) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: load on emit, clear on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
